@@ src/lcs_pkg.sv @@
// lcs_pkg: shared types and constants of the longest common subsequence unit
// used by lcs_cell and longest_common_subsequence_unit; no dependencies
package lcs_pkg;

   // field widths, sized for the largest supported string length of 64
   localparam int LEN_W = 7;
   localparam int SYM_W = 8;
   localparam int COL_W = 6;

   // traceback direction codes
   typedef logic [1:0] dir_type;
   localparam dir_type DIR_DIAG = 2'd0;
   localparam dir_type DIR_UP   = 2'd1;
   localparam dir_type DIR_LEFT = 2'd2;

   // column data handed from one cell to the next
   typedef struct packed {
      logic             valid;
      logic [SYM_W-1:0] sym;
      logic [LEN_W-1:0] score;
      logic [COL_W-1:0] col;
   } link_type;

endpackage

@@ src/lcs_cell.sv @@
// lcs_cell: one row of the score table; holds one first-string symbol,
// its running row score and its row of traceback directions
// depends on lcs_pkg
module lcs_cell #(
   parameter int MAX_LEN = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      load_en,
   input  logic [lcs_pkg::SYM_W-1:0] load_sym,
   input  lcs_pkg::link_type         link_in,
   output lcs_pkg::link_type         link_out,
   input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] rd_col,
   output lcs_pkg::dir_type          rd_dir,
   output logic [lcs_pkg::SYM_W-1:0] row_sym
);
   import lcs_pkg::*;

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   logic [SYM_W-1:0] sym_ff;
   logic [LEN_W-1:0] left_ff;
   logic [LEN_W-1:0] diag_ff;
   link_type         link_ff;
   dir_type          dir_mem [MAX_LEN];
   dir_type          rd_dir_ff;
   logic [LEN_W-1:0] score_in;
   dir_type          dir_in;

   // recurrence: match takes diagonal plus one, else up on ties, else left
   always_comb begin
      if (sym_ff == link_in.sym) begin
         score_in = diag_ff + LEN_W'(1);
         dir_in   = DIR_DIAG;
      end else if (link_in.score >= left_ff) begin
         score_in = link_in.score;
         dir_in   = DIR_UP;
      end else begin
         score_in = left_ff;
         dir_in   = DIR_LEFT;
      end
   end

   // row symbol
   always_ff @(posedge clock) begin
      if (load_en) begin
         sym_ff <= load_sym;
      end
   end

   // running left and diagonal scores
   always_ff @(posedge clock) begin
      if (start) begin
         left_ff <= '0;
         diag_ff <= '0;
      end else if (link_in.valid) begin
         left_ff <= score_in;
         diag_ff <= link_in.score;
      end
   end

   // hand the column on to the next row
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else begin
         link_ff.valid <= link_in.valid;
      end
      link_ff.sym   <= link_in.sym;
      link_ff.score <= score_in;
      link_ff.col   <= link_in.col;
   end

   // direction row memory
   always_ff @(posedge clock) begin
      if (link_in.valid) begin
         dir_mem[link_in.col[AW-1:0]] <= dir_in;
      end
      rd_dir_ff <= dir_mem[rd_col];
   end

   assign link_out = link_ff;
   assign rd_dir   = rd_dir_ff;
   assign row_sym  = sym_ff;

endmodule

@@ src/longest_common_subsequence_unit.sv @@
// longest_common_subsequence_unit: top level, loads both strings, runs the
// cell chain, traces back and returns the subsequence
// depends on lcs_pkg and lcs_cell
//
// Usage: requests carry req_mode (0 first string, 1 second string),
// req_symbol and req_last. A request is taken when req_valid is high and
// req_stall low. While loading, one request is taken every cycle. The
// request with mode 1 and last set starts a run; req_stall stays high until
// the run's last response has been taken.
// A run: the chain of MAX_LEN cells sweeps the second string past the
// first (n, m the string lengths), then the traceback reads and evaluates
// one step at a time, at most n + m steps, using the per-row direction
// memories; then each response is read, loaded and held until taken.
// Responses hold one subsequence symbol each, in forward order, with the
// length and the truncation flag; rsp_final_res marks the last one. An
// empty subsequence gives one response with rsp_symbol_valid low.
// A stalled response holds its payload until rsp_stall drops.
// Reset clears both lengths, the flags and the state; no memory is cleared.
module longest_common_subsequence_unit #(
   parameter int MAX_LEN = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_mode,
   input  logic [lcs_pkg::SYM_W-1:0] req_symbol,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [lcs_pkg::LEN_W-1:0] rsp_common_length,
   output logic [lcs_pkg::SYM_W-1:0] rsp_out_symbol,
   output logic                      rsp_symbol_valid,
   output logic                      rsp_final_res,
   output logic                      rsp_truncated
);
   import lcs_pkg::*;

   localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW  = LEN_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FILL, ST_TR_RD, ST_TR_EV, ST_EM_RD, ST_EM_LD, ST_EM_WT
   } state_type;

   state_type        state_ff;
   logic [LEN_W-1:0] flen_ff;
   logic [LEN_W-1:0] slen_ff;
   logic             ovf_ff;
   logic             closed_ff;
   logic [CW-1:0]    cnt_ff;
   logic [LEN_W-1:0] ti_ff;
   logic [LEN_W-1:0] tj_ff;
   logic [LEN_W-1:0] k_ff;
   logic [LEN_W-1:0] e_ff;
   logic             inj_ff;
   logic [COL_W-1:0] inj_col_ff;
   logic [SYM_W-1:0] s_rd_ff;
   logic [SYM_W-1:0] rb_rd_ff;
   logic [SYM_W-1:0] smem [MAX_LEN];
   logic [SYM_W-1:0] rbuf [MAX_LEN];

   logic             rsp_valid_ff;
   logic [LEN_W-1:0] rsp_len_ff;
   logic [SYM_W-1:0] rsp_sym_ff;
   logic             rsp_sv_ff;
   logic             rsp_fin_ff;
   logic             rsp_tr_ff;

   logic             accept;
   logic             load_first;
   logic             start;
   link_type         link [MAX_LEN+1];
   dir_type          cell_dir [MAX_LEN];
   logic [SYM_W-1:0] cell_sym [MAX_LEN];
   logic [AW-1:0]    tr_col;
   logic [AW-1:0]    tr_row;
   dir_type          dir_sel;
   logic [SYM_W-1:0] sym_sel;
   logic [AW-1:0]    em_addr;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign load_first = accept && !req_mode && !closed_ff &&
                       (flen_ff < LEN_W'(MAX_LEN));
   assign start      = accept && req_mode && req_last;

   // chain of cells, fed at row 0 with zero up scores
   assign link[0].valid = inj_ff;
   assign link[0].sym   = s_rd_ff;
   assign link[0].score = '0;
   assign link[0].col   = inj_col_ff;

   assign tr_col = AW'(tj_ff - LEN_W'(1));
   assign tr_row = AW'(ti_ff - LEN_W'(1));

   genvar gi;
   generate
      for (gi = 0; gi < MAX_LEN; gi++) begin : g_cell
         lcs_cell #(.MAX_LEN(MAX_LEN)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .start    (start),
            .load_en  (load_first && (flen_ff == LEN_W'(gi))),
            .load_sym (req_symbol),
            .link_in  (link[gi]),
            .link_out (link[gi+1]),
            .rd_col   (tr_col),
            .rd_dir   (cell_dir[gi]),
            .row_sym  (cell_sym[gi])
         );
      end
   endgenerate

   // row select for the traceback
   assign dir_sel = cell_dir[tr_row];
   assign sym_sel = cell_sym[tr_row];
   assign em_addr = AW'(k_ff - LEN_W'(1) - e_ff);

   // second string store and its feed into the chain
   always_ff @(posedge clock) begin
      if (accept && req_mode && (slen_ff < LEN_W'(MAX_LEN))) begin
         smem[slen_ff[AW-1:0]] <= req_symbol;
      end
      s_rd_ff    <= smem[cnt_ff[AW-1:0]];
      inj_col_ff <= COL_W'(cnt_ff);
   end

   // result buffer, filled in reverse during traceback
   always_ff @(posedge clock) begin
      if ((state_ff == ST_TR_EV) && (dir_sel == DIR_DIAG)) begin
         rbuf[k_ff[AW-1:0]] <= sym_sel;
      end
      rb_rd_ff <= rbuf[em_addr];
   end

   // control and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flen_ff      <= '0;
         slen_ff      <= '0;
         ovf_ff       <= 1'b0;
         closed_ff    <= 1'b0;
         cnt_ff       <= '0;
         inj_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         inj_ff <= (state_ff == ST_FILL) && (cnt_ff < CW'(slen_ff));
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && !req_mode && !closed_ff) begin
                  if (flen_ff < LEN_W'(MAX_LEN)) begin
                     flen_ff <= flen_ff + LEN_W'(1);
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  if (req_last) begin
                     closed_ff <= 1'b1;
                  end
               end
               if (accept && req_mode) begin
                  if (slen_ff < LEN_W'(MAX_LEN)) begin
                     slen_ff <= slen_ff + LEN_W'(1);
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  if (req_last) begin
                     cnt_ff   <= '0;
                     state_ff <= ST_FILL;
                  end
               end
            end
            ST_FILL: begin
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == CW'(slen_ff) + CW'(flen_ff) + CW'(2)) begin
                  ti_ff    <= flen_ff;
                  tj_ff    <= slen_ff;
                  k_ff     <= '0;
                  state_ff <= ST_TR_RD;
               end
            end
            ST_TR_RD: begin
               if ((ti_ff == '0) || (tj_ff == '0)) begin
                  e_ff <= '0;
                  if (k_ff == '0) begin
                     rsp_len_ff   <= '0;
                     rsp_sym_ff   <= '0;
                     rsp_sv_ff    <= 1'b0;
                     rsp_fin_ff   <= 1'b1;
                     rsp_tr_ff    <= ovf_ff;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_EM_WT;
                  end else begin
                     state_ff <= ST_EM_RD;
                  end
               end else begin
                  state_ff <= ST_TR_EV;
               end
            end
            ST_TR_EV: begin
               case (dir_sel)
                  DIR_DIAG: begin
                     k_ff  <= k_ff + LEN_W'(1);
                     ti_ff <= ti_ff - LEN_W'(1);
                     tj_ff <= tj_ff - LEN_W'(1);
                  end
                  DIR_UP: begin
                     ti_ff <= ti_ff - LEN_W'(1);
                  end
                  default: begin
                     tj_ff <= tj_ff - LEN_W'(1);
                  end
               endcase
               state_ff <= ST_TR_RD;
            end
            ST_EM_RD: begin
               state_ff <= ST_EM_LD;
            end
            ST_EM_LD: begin
               rsp_len_ff   <= k_ff;
               rsp_sym_ff   <= rb_rd_ff;
               rsp_sv_ff    <= 1'b1;
               rsp_fin_ff   <= (e_ff + LEN_W'(1) == k_ff);
               rsp_tr_ff    <= ovf_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_EM_WT;
            end
            ST_EM_WT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_fin_ff) begin
                     flen_ff   <= '0;
                     slen_ff   <= '0;
                     ovf_ff    <= 1'b0;
                     closed_ff <= 1'b0;
                     state_ff  <= ST_IDLE;
                  end else begin
                     e_ff     <= e_ff + LEN_W'(1);
                     state_ff <= ST_EM_RD;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_common_length = rsp_len_ff;
   assign rsp_out_symbol    = rsp_sym_ff;
   assign rsp_symbol_valid  = rsp_sv_ff;
   assign rsp_final_res     = rsp_fin_ff;
   assign rsp_truncated     = rsp_tr_ff;

endmodule

@@ tb/tb_longest_common_subsequence_unit.sv @@
// tb_longest_common_subsequence_unit: self-checking bench for the longest common
// subsequence unit, with a behavioral predictor and a scoreboard of responses
// depends on lcs_pkg and longest_common_subsequence_unit
`timescale 1ns / 100ps

module tb_longest_common_subsequence_unit;
   import lcs_pkg::*;

   localparam int CAP = 64;
   localparam int CYCLE_LIMIT = 600000;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic [LEN_W-1:0] length;
      logic [SYM_W-1:0] sym;
      logic             sym_valid;
      logic             final_res;
      logic             trunc;
   } subseq_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_mode = 0;
   logic [SYM_W-1:0] req_symbol = '0;
   logic req_last = 0;
   logic rsp_stall = 0;
   logic req_stall;
   logic rsp_valid;
   logic [LEN_W-1:0] rsp_common_length;
   logic [SYM_W-1:0] rsp_out_symbol;
   logic rsp_symbol_valid, rsp_final_res, rsp_truncated;

   // predictor state
   logic [SYM_W-1:0] str_a [CAP];
   logic [SYM_W-1:0] str_b [CAP];
   int len_a, len_b;
   bit over_flag, a_closed;
   subseq_rsp_type pending_rsp [$];

   int send_idle_pct, stall_pct;
   int requests_sent, runs_done, rsps_checked, mismatches, cycles;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   longest_common_subsequence_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_symbol(req_symbol), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_common_length(rsp_common_length), .rsp_out_symbol(rsp_out_symbol),
      .rsp_symbol_valid(rsp_symbol_valid), .rsp_final_res(rsp_final_res),
      .rsp_truncated(rsp_truncated)
   );

   // fill score and direction tables, trace back, queue the responses
   task automatic solve_lcs();
      int score [CAP+1][CAP+1];
      dir_type dir [CAP][CAP];
      logic [SYM_W-1:0] subseq [CAP];
      int i, j, pos, total;
      subseq_rsp_type r;
      for (i = 0; i <= len_a; i++) score[i][0] = 0;
      for (j = 0; j <= len_b; j++) score[0][j] = 0;
      for (i = 1; i <= len_a; i++) begin
         for (j = 1; j <= len_b; j++) begin
            if (str_a[i-1] == str_b[j-1]) begin
               score[i][j] = score[i-1][j-1] + 1;
               dir[i-1][j-1] = DIR_DIAG;
            end else if (score[i-1][j] >= score[i][j-1]) begin
               score[i][j] = score[i-1][j];
               dir[i-1][j-1] = DIR_UP;
            end else begin
               score[i][j] = score[i][j-1];
               dir[i-1][j-1] = DIR_LEFT;
            end
         end
      end
      total = score[len_a][len_b];
      pos = total;
      i = len_a;
      j = len_b;
      while (i > 0 && j > 0) begin
         if (dir[i-1][j-1] == DIR_DIAG) begin
            pos--;
            subseq[pos] = str_a[i-1];
            i--;
            j--;
         end else if (dir[i-1][j-1] == DIR_UP) i--;
         else j--;
      end
      r.trunc = over_flag;
      r.length = LEN_W'(total);
      if (total == 0) begin
         r.sym = '0;
         r.sym_valid = 1'b0;
         r.final_res = 1'b1;
         pending_rsp.push_back(r);
      end else begin
         for (int k = 0; k < total; k++) begin
            r.sym = subseq[k];
            r.sym_valid = 1'b1;
            r.final_res = (k == total - 1);
            pending_rsp.push_back(r);
         end
      end
      runs_done++;
   endtask

   // update predictor with one accepted request
   task automatic predict_request(logic mode, logic [SYM_W-1:0] sym, logic last);
      if (mode == 0) begin
         if (!a_closed) begin
            if (len_a < CAP) str_a[len_a++] = sym;
            else over_flag = 1;
            if (last) a_closed = 1;
         end
      end else begin
         if (len_b < CAP) str_b[len_b++] = sym;
         else over_flag = 1;
         if (last) begin
            solve_lcs();
            len_a = 0;
            len_b = 0;
            over_flag = 0;
            a_closed = 0;
         end
      end
   endtask

   // drive one request at the falling edge and wait until it is taken
   task automatic send_request(logic mode, logic [SYM_W-1:0] sym, logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_mode <= mode;
      req_symbol <= sym;
      req_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(mode, sym, last);
      requests_sent++;
   endtask

   task automatic go_quiet();
      @(negedge clock);
      req_valid <= 0;
   endtask

   // hold off until every predicted response has been seen
   task automatic drain_responses();
      go_quiet();
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic logic [SYM_W-1:0] pick_symbol(int alphabet);
      if (alphabet == 0) return SYM_W'($urandom_range(0, 255));
      return SYM_W'(8'h30 + $urandom_range(0, alphabet - 1));
   endfunction

   task automatic send_string(logic mode, int count, bit close, int alphabet);
      for (int k = 0; k < count; k++)
         send_request(mode, pick_symbol(alphabet), close && (k == count - 1));
   endtask

   // extremes, ignored first-string symbols, empty results, early close
   task automatic test_directed();
      send_request(0, 8'h00, 0);
      send_request(0, 8'hFF, 0);
      send_request(0, 8'h5A, 1);
      send_request(0, 8'hA5, 0);
      send_request(1, 8'hFF, 0);
      send_request(1, 8'h5A, 0);
      send_request(1, 8'h00, 1);
      // no common symbol
      send_request(0, 8'h01, 1);
      send_request(1, 8'h02, 1);
      // empty first string
      send_request(1, 8'h07, 1);
      // second string closes while the first is still open
      send_request(0, 8'h03, 0);
      send_request(0, 8'h04, 0);
      send_request(1, 8'h04, 1);
      // identical strings
      send_request(0, 8'h80, 0);
      send_request(0, 8'h7F, 1);
      send_request(1, 8'h80, 0);
      send_request(1, 8'h7F, 1);
   endtask

   // strings longer than the capacity on either side
   task automatic test_overflow();
      send_string(0, CAP + 2, 1, 3);
      send_string(1, CAP + 3, 1, 3);
      send_string(0, 5, 1, 2);
      send_string(1, CAP + 1, 1, 2);
   endtask

   // random runs: mostly well-formed pairs of short strings, some noise
   task automatic test_random(int target);
      int m, n, alphabet;
      target += requests_sent;
      while (requests_sent < target) begin
         m = $urandom_range(0, 9);
         n = $urandom_range(1, 9);
         alphabet = ($urandom_range(3) == 0) ? 0 : $urandom_range(2, 5);
         if ($urandom_range(9) == 0) begin
            send_string(0, m, 0, alphabet);
         end else begin
            send_string(0, m, 1, alphabet);
            if ($urandom_range(4) == 0) send_string(0, $urandom_range(1, 2), 1, 0);
         end
         send_string(1, n, 1, alphabet);
      end
   endtask

   // response checker
   always @(posedge clock) begin
      subseq_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsps_checked++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response: length %0d symbol %h",
                        rsp_common_length, rsp_out_symbol);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_common_length !== e.length || rsp_out_symbol !== e.sym ||
                rsp_symbol_valid !== e.sym_valid || rsp_final_res !== e.final_res ||
                rsp_truncated !== e.trunc) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("mismatch: exp len %0d sym %h sv %b fin %b tr %b, ",
                           "got len %0d sym %h sv %b fin %b tr %b",
                           e.length, e.sym, e.sym_valid, e.final_res, e.trunc,
                           rsp_common_length, rsp_out_symbol, rsp_symbol_valid,
                           rsp_final_res, rsp_truncated);
            end
         end
      end
   end

   // receiver stall
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      len_a = 0;
      len_b = 0;
      over_flag = 0;
      a_closed = 0;
      send_idle_pct = 15;
      stall_pct = 45;
      requests_sent = 0;
      runs_done = 0;
      rsps_checked = 0;
      mismatches = 0;
      cycles = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_overflow();
      test_random(15);
      drain_responses();
      send_idle_pct = 45;
      stall_pct = 15;
      test_random(15);
      send_idle_pct = 0;
      stall_pct = 0;
      test_random(10);
      go_quiet();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("sent %0d requests in %0d runs, checked %0d responses, %0d mismatches",
               requests_sent, runs_done, rsps_checked, mismatches);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
